@@ design/lpf_pkg.sv @@
// Shared types, register codes and reset values for the 3x3 low-pass filter.
package lpf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int CFG_DATA_W    = 24;
  localparam int CFG_ADDR_W    = 3;
  localparam int DIV_W         = 12;
  localparam int WIDTH_CFG_W   = 11;
  localparam int HEIGHT_W      = 16;
  localparam int SUM_W         = 20;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_W_TOP   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_W_MID   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_W_BOT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DIVISOR = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT  = 3'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_DATA_W-1:0]  RST_W_TOP   = 24'd66049;
  localparam logic [CFG_DATA_W-1:0]  RST_W_MID   = 24'd132098;
  localparam logic [CFG_DATA_W-1:0]  RST_W_BOT   = 24'd66049;
  localparam logic [DIV_W-1:0]       RST_DIVISOR = 12'd16;
  localparam logic [WIDTH_CFG_W-1:0] RST_WIDTH   = 11'd1024;
  localparam logic [HEIGHT_W-1:0]    RST_HEIGHT  = 16'd1;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_value;
    logic             frame_last;
  } out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]  weights_top_row;
    logic [CFG_DATA_W-1:0]  weights_middle_row;
    logic [CFG_DATA_W-1:0]  weights_bottom_row;
    logic [DIV_W-1:0]       divisor;
    logic [WIDTH_CFG_W-1:0] image_width;
    logic [HEIGHT_W-1:0]    image_height;
  } cfg_t;

  // Masked 3x3 neighborhood, entry row*3+column, plus the end-of-frame flag.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic                  last;
  } job_t;

endpackage

@@ design/lpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lpf_fifo.sv @@
// Small register FIFO used between front, back and the result port.
module lpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/lpf_front.sv @@
// Front end: accepts pixels, keeps line stores, window and frame position, emits jobs.
module lpf_front import lpf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cfg_we,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic jq_push,
  output job_t jq_data,
  input  logic jq_full
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int TW   = WW + HEIGHT_W;
  localparam int CNTW = $clog2(TW + 1);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_IDLE = 2'd2;
  localparam logic [1:0] S_READ = 2'd3;

  logic [1:0]            state;
  logic [WW-1:0]         w_eff;
  logic [HEIGHT_W-1:0]   h_eff;
  logic [TW-1:0]         area;
  logic [TW-1:0]         total;
  logic [TW-1:0]         emitted;
  logic [TW-1:0]         orow;
  logic [WW-1:0]         ocol;
  logic [AW-1:0]         col;
  logic [1:0]            row;
  logic [CNTW-1:0]       div_cnt;
  logic [PIX_W-1:0]      pix_v;
  logic [8:0][PIX_W-1:0] win;
  logic [8:0][PIX_W-1:0] win_next;

  logic                  accept;
  logic                  restart;
  logic [AW-1:0]         col_pre;
  logic [1:0]            row_pre;
  logic                  wrap_pre;
  logic [AW-1:0]         c_sel;
  logic [1:0]            row_acc;

  logic [PIX_W-1:0]      prev_rd;
  logic [PIX_W-1:0]      prev2_rd;
  logic                  ram_we;

  logic                  ready;
  logic                  col_wrap;
  logic                  m_top;
  logic                  m_bot;
  logic                  m_left;
  logic                  m_right;
  logic                  last;
  logic [WW:0]           rem_sh;
  logic                  rem_ge;

  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.image_width);
    end
    h_eff = (cfg.image_height == '0) ? HEIGHT_W'(1) : cfg.image_height;
  end

  assign area = {{HEIGHT_W{1'b0}}, w_eff} * {{WW{1'b0}}, h_eff};

  assign full   = !(state == S_IDLE && !jq_full && !cfg_we);
  assign accept = push && !full;

  // Position seen by an accepted item: frame restart first, then column wrap.
  always_comb begin
    restart  = (emitted >= total);
    col_pre  = restart ? '0 : col;
    row_pre  = restart ? 2'd0 : row;
    wrap_pre = (32'(col_pre) >= 32'(w_eff));
    c_sel    = wrap_pre ? '0 : col_pre;
    row_acc  = (wrap_pre && row_pre != 2'd2) ? row_pre + 2'd1 : row_pre;
  end

  assign ram_we = (state == S_READ);

  lpf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col),
    .wdata(pix_v),
    .raddr(c_sel),
    .rdata(prev_rd)
  );

  lpf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev2 (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col),
    .wdata(prev_rd),
    .raddr(c_sel),
    .rdata(prev2_rd)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = prev2_rd;
    win_next[5] = prev_rd;
    win_next[8] = pix_v;

    ready    = (row == 2'd2) || (row == 2'd1 && col != '0);
    col_wrap = (32'(col) + 32'd1 >= 32'(w_eff));
    m_top    = (orow == '0);
    m_bot    = ({1'b0, orow} + (TW+1)'(1)) >= (TW+1)'(h_eff);
    m_left   = (ocol == '0);
    m_right  = ({1'b0, ocol} + (WW+1)'(1)) >= {1'b0, w_eff};
    last     = ((emitted + TW'(1)) == total);

    for (int r = 0; r < 3; r++) begin
      for (int t = 0; t < 3; t++) begin
        if ((r == 0 && m_top) || (r == 2 && m_bot) ||
            (t == 0 && m_left) || (t == 2 && m_right)) begin
          jq_data.pix[r*3+t] = '0;
        end else begin
          jq_data.pix[r*3+t] = win_next[r*3+t];
        end
      end
    end
    jq_data.last = last;
  end

  assign jq_push = (state == S_READ) && ready;

  // Restoring division of the output count by the width rebuilds row and column.
  assign rem_sh = {ocol, orow[TW-1]};
  assign rem_ge = (rem_sh >= {1'b0, w_eff});

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      win <= win_next;
    end
    if (accept) begin
      pix_v <= (item.opcode == OP_FLUSH) ? '0 : item.pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      total   <= '0;
      emitted <= '0;
      orow    <= '0;
      ocol    <= '0;
      col     <= '0;
      row     <= 2'd0;
      div_cnt <= '0;
    end else if (cfg_we) begin
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT: begin
          total   <= area;
          orow    <= emitted;
          ocol    <= '0;
          div_cnt <= CNTW'(TW);
          state   <= S_DIV;
        end
        S_DIV: begin
          ocol    <= rem_ge ? WW'(rem_sh - {1'b0, w_eff}) : rem_sh[WW-1:0];
          orow    <= {orow[TW-2:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == CNTW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (restart) begin
              emitted <= '0;
              orow    <= '0;
              ocol    <= '0;
            end
            col   <= c_sel;
            row   <= row_acc;
            state <= S_READ;
          end
        end
        S_READ: begin
          col <= col_wrap ? '0 : col + 1'b1;
          if (col_wrap && row != 2'd2) begin
            row <= row + 2'd1;
          end
          if (ready) begin
            emitted <= emitted + 1'b1;
            if (m_right) begin
              ocol <= '0;
              orow <= orow + 1'b1;
            end else begin
              ocol <= ocol + 1'b1;
            end
            if (last) begin
              emitted <= '0;
              orow    <= '0;
              ocol    <= '0;
              col     <= '0;
              row     <= 2'd0;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

@@ design/lpf_back.sv @@
// Back end: weighted sum over the window, iterative divide, result push.
module lpf_back import lpf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic jq_empty,
  output logic jq_pop,
  input  job_t jq_data,
  input  logic oq_full,
  output logic oq_push,
  output out_t oq_data
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MAC  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  localparam int CNTW = $clog2(SUM_W + 1);

  logic [1:0]           state;
  job_t                 job;
  logic [3:0]           idx;
  logic [SUM_W-1:0]     acc;
  logic [DIV_W-1:0]     rem;
  logic [CNTW-1:0]      cnt;
  logic [PIX_W-1:0]     wgt;
  logic [2*PIX_W-1:0]   prod;
  logic [DIV_W-1:0]     d_eff;
  logic [DIV_W:0]       rem_sh;
  logic                 rem_ge;

  function automatic logic [PIX_W-1:0] weight_of(cfg_t c, logic [3:0] i);
    logic [PIX_W-1:0] w;
    case (i)
      4'd0:    w = c.weights_top_row[7:0];
      4'd1:    w = c.weights_top_row[15:8];
      4'd2:    w = c.weights_top_row[23:16];
      4'd3:    w = c.weights_middle_row[7:0];
      4'd4:    w = c.weights_middle_row[15:8];
      4'd5:    w = c.weights_middle_row[23:16];
      4'd6:    w = c.weights_bottom_row[7:0];
      4'd7:    w = c.weights_bottom_row[15:8];
      4'd8:    w = c.weights_bottom_row[23:16];
      default: w = '0;
    endcase
    return w;
  endfunction

  assign wgt    = weight_of(cfg, idx);
  assign prod   = wgt * job.pix[idx];
  assign d_eff  = (cfg.divisor == '0) ? DIV_W'(1) : cfg.divisor;
  assign rem_sh = {rem, acc[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, d_eff});

  assign jq_pop  = (state == B_IDLE) && !jq_empty && !oq_full;
  assign oq_push = (state == B_DONE);
  assign oq_data.filtered_value = acc[PIX_W-1:0];
  assign oq_data.frame_last     = job.last;

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      job <= jq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
      acc   <= '0;
      rem   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (jq_pop) begin
            idx   <= '0;
            acc   <= '0;
            state <= B_MAC;
          end
        end
        B_MAC: begin
          acc <= acc + SUM_W'(prod);
          idx <= idx + 1'b1;
          if (idx == 4'd8) begin
            rem   <= '0;
            cnt   <= CNTW'(SUM_W);
            state <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= rem_ge ? DIV_W'(rem_sh - {1'b0, d_eff}) : rem_sh[DIV_W-1:0];
          acc <= {acc[SUM_W-2:0], rem_ge};
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ design/weighted_3x3_lowpass_filter_core.sv @@
// Top level of the 3x3 weighted low-pass filter: config registers, front, queues, back.
// The front takes no new item while it is storing the last one; the back end
// takes no new job until it has pushed its result, working through a pop, nine
// multiply-accumulate steps, a 20-step divide and a push for each result.
// Reset (rst, synchronous) restores register defaults, empties both queues, and then
// holds full while frame position is rebuilt; a config write also holds full while it is rebuilt.
module weighted_3x3_lowpass_filter_core import lpf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  in_t                   in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  out_data
);

  cfg_t cfg;
  logic jq_push;
  logic jq_pop;
  logic jq_full;
  logic jq_empty;
  job_t jq_din;
  job_t jq_dout;
  logic oq_push;
  logic oq_full;
  out_t oq_din;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weights_top_row    <= RST_W_TOP;
      cfg.weights_middle_row <= RST_W_MID;
      cfg.weights_bottom_row <= RST_W_BOT;
      cfg.divisor            <= RST_DIVISOR;
      cfg.image_width        <= RST_WIDTH;
      cfg.image_height       <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_W_TOP:   cfg.weights_top_row    <= cfg_wdata;
        REG_W_MID:   cfg.weights_middle_row <= cfg_wdata;
        REG_W_BOT:   cfg.weights_bottom_row <= cfg_wdata;
        REG_DIVISOR: cfg.divisor            <= cfg_wdata[DIV_W-1:0];
        REG_WIDTH:   cfg.image_width        <= cfg_wdata[WIDTH_CFG_W-1:0];
        REG_HEIGHT:  cfg.image_height       <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  lpf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cfg_we (cfg_we),
    .push   (push),
    .full   (full),
    .item   (in_data),
    .jq_push(jq_push),
    .jq_data(jq_din),
    .jq_full(jq_full)
  );

  lpf_fifo #(.WIDTH($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .push (jq_push),
    .din  (jq_din),
    .pop  (jq_pop),
    .dout (jq_dout),
    .full (jq_full),
    .empty(jq_empty)
  );

  lpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .jq_empty(jq_empty),
    .jq_pop  (jq_pop),
    .jq_data (jq_dout),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_din)
  );

  lpf_fifo #(.WIDTH($bits(out_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (oq_push),
    .din  (oq_din),
    .pop  (pop),
    .dout (out_data),
    .full (oq_full),
    .empty(empty)
  );

  // The front only emits a job when it has checked for room at accept time.
  a_job_room: assert property (@(posedge clk) disable iff (rst) jq_push |-> !jq_full)
    else $error("job queue overrun");

  // The back end only starts a job when the result queue has room.
  a_out_room: assert property (@(posedge clk) disable iff (rst) oq_push |-> !oq_full)
    else $error("result queue overrun");

  // After reset the front is rebuilding its position and takes no transaction.
  a_rst_full: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  // Nothing is left waiting at the result port after reset.
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

endmodule
